/* rtl/kpct_pkg.sv */
`timescale 1ns / 1ps

package kpct_pkg;

	localparam int KNOB_COUNT     = 4;
	localparam int SAMPLE_BITS    = 10;
	localparam int REG_BITS       = 10;
	localparam int CFG_INDEX_BITS = 2;
	localparam int ACTION_BITS    = 3;
	localparam int INDEX_BITS     = 2;

	// Action codes
	localparam logic [ACTION_BITS-1:0] ACT_SWEEP        = 3'd0;
	localparam logic [ACTION_BITS-1:0] ACT_FREEZE_ONE   = 3'd1;
	localparam logic [ACTION_BITS-1:0] ACT_UNFREEZE_ONE = 3'd2;
	localparam logic [ACTION_BITS-1:0] ACT_FREEZE_ALL   = 3'd3;
	localparam logic [ACTION_BITS-1:0] ACT_UNFREEZE_ALL = 3'd4;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_FREEZE_DISTANCE   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CHANGE_TOLERANCE  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_EXTERNAL_UNFREEZE = 2'd2;

	// Register reset values
	localparam logic [REG_BITS-1:0] FREEZE_DISTANCE_RST  = 10'd8;
	localparam logic [REG_BITS-1:0] CHANGE_TOLERANCE_RST = 10'd2;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [KNOB_COUNT-1:0]  knob_mask_t;

	typedef struct packed {
		logic [ACTION_BITS-1:0] action;
		logic [INDEX_BITS-1:0]  knob_index;
		sample_t                sample_zero;
		sample_t                sample_one;
		sample_t                sample_two;
		sample_t                sample_three;
	} in_item_t;

	typedef struct packed {
		knob_mask_t changed_mask;
		knob_mask_t frozen_mask;
		sample_t    value_zero;
		sample_t    value_one;
		sample_t    value_two;
		sample_t    value_three;
		sample_t    previous_zero;
		sample_t    previous_one;
		sample_t    previous_two;
		sample_t    previous_three;
	} out_item_t;

	typedef struct packed {
		logic [REG_BITS-1:0] freeze_distance;
		logic [REG_BITS-1:0] change_tolerance;
		logic                external_unfreeze;
	} cfg_t;

	typedef struct packed {
		logic unfreeze;
		logic moved;
	} lane_res_t;

endpackage

/* rtl/knob_pickup_change_tracker_top.sv */
`timescale 1ns / 1ps

// Knob pickup change tracker: holds the current and previous reading of four
// 10-bit knobs, a frozen mask and a changed mask. Sweep items compare each new
// sample against the stored value, update the masks and shift the values; the other actions
// freeze or unfreeze one or all knobs. Every accepted item returns exactly one
// result with both masks and all stored values. An item is held in the input
// register and moves into the result register once that register is free or
// drains, so its result is offered from the result register; a new item is taken
// every cycle while the result side is ready; the per-knob subtract and two
// compares between those registers set that pace. Configuration writes take
// effect on the next cycle and belong to idle periods.
module knob_pickup_change_tracker_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  kpct_pkg::in_item_t                  item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output kpct_pkg::out_item_t                 result,
	input  logic                                cfg_we,
	input  logic [kpct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [kpct_pkg::REG_BITS-1:0]       cfg_data
);

	kpct_pkg::cfg_t      cfg;
	logic                valid_s1;
	kpct_pkg::in_item_t  item_s1;
	logic                result_valid_s2;
	kpct_pkg::out_item_t result_s2;
	logic                advance;
	logic                commit;

	kpct_pkg::sample_t   knob_q  [kpct_pkg::KNOB_COUNT];
	kpct_pkg::sample_t   prior_q [kpct_pkg::KNOB_COUNT];
	kpct_pkg::knob_mask_t frozen_q;
	kpct_pkg::knob_mask_t moved_q;

	kpct_pkg::sample_t   samples   [kpct_pkg::KNOB_COUNT];
	kpct_pkg::sample_t   knob_nxt  [kpct_pkg::KNOB_COUNT];
	kpct_pkg::sample_t   prior_nxt [kpct_pkg::KNOB_COUNT];
	kpct_pkg::lane_res_t lane_res  [kpct_pkg::KNOB_COUNT];
	kpct_pkg::knob_mask_t unfreeze_mask;
	kpct_pkg::knob_mask_t moved_mask;
	kpct_pkg::knob_mask_t frozen_nxt;
	kpct_pkg::knob_mask_t moved_nxt;
	logic                sweep;

	kpct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake: stage 1 moves on when the result register is free or drains
	assign advance    = !result_valid_s2 || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign commit     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Unpack the samples into lane order
	assign samples[0] = item_s1.sample_zero;
	assign samples[1] = item_s1.sample_one;
	assign samples[2] = item_s1.sample_two;
	assign samples[3] = item_s1.sample_three;

	for (genvar k = 0; k < kpct_pkg::KNOB_COUNT; k++) begin : g_lane
		kpct_lane u_lane (
			.fresh  (samples[k]),
			.stored (knob_q[k]),
			.frozen (frozen_q[k]),
			.cfg    (cfg),
			.res    (lane_res[k])
		);
	end

	// Gather per-lane decisions into masks
	always_comb begin
		for (int k = 0; k < kpct_pkg::KNOB_COUNT; k++) begin
			unfreeze_mask[k] = lane_res[k].unfreeze;
			moved_mask[k]    = lane_res[k].moved;
		end
	end

	// Decode the action into the next mask state
	always_comb begin
		frozen_nxt = frozen_q;
		moved_nxt  = moved_q;
		sweep      = 1'b0;
		unique case (item_s1.action)
			kpct_pkg::ACT_SWEEP: begin
				frozen_nxt = frozen_q & ~unfreeze_mask;
				moved_nxt  = moved_mask;
				sweep      = 1'b1;
			end
			kpct_pkg::ACT_FREEZE_ONE: begin
				frozen_nxt = frozen_q |
					(kpct_pkg::knob_mask_t'(1) << item_s1.knob_index);
			end
			kpct_pkg::ACT_UNFREEZE_ONE: begin
				frozen_nxt = frozen_q &
					~(kpct_pkg::knob_mask_t'(1) << item_s1.knob_index);
			end
			kpct_pkg::ACT_FREEZE_ALL: begin
				frozen_nxt = '1;
			end
			kpct_pkg::ACT_UNFREEZE_ALL: begin
				frozen_nxt = '0;
			end
			default: ;
		endcase
	end

	// Shift values on a sweep, hold them otherwise
	always_comb begin
		for (int k = 0; k < kpct_pkg::KNOB_COUNT; k++) begin
			knob_nxt[k]  = sweep ? samples[k] : knob_q[k];
			prior_nxt[k] = sweep ? knob_q[k]  : prior_q[k];
		end
	end

	// Update tracker state when the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < kpct_pkg::KNOB_COUNT; k++) begin
				knob_q[k]  <= '0;
				prior_q[k] <= '0;
			end
			frozen_q <= '0;
			moved_q  <= '0;
		end else if (commit) begin
			for (int k = 0; k < kpct_pkg::KNOB_COUNT; k++) begin
				knob_q[k]  <= knob_nxt[k];
				prior_q[k] <= prior_nxt[k];
			end
			frozen_q <= frozen_nxt;
			moved_q  <= moved_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_s2.changed_mask   <= moved_nxt;
			result_s2.frozen_mask    <= frozen_nxt;
			result_s2.value_zero     <= knob_nxt[0];
			result_s2.value_one      <= knob_nxt[1];
			result_s2.value_two      <= knob_nxt[2];
			result_s2.value_three    <= knob_nxt[3];
			result_s2.previous_zero  <= prior_nxt[0];
			result_s2.previous_one   <= prior_nxt[1];
			result_s2.previous_two   <= prior_nxt[2];
			result_s2.previous_three <= prior_nxt[3];
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

endmodule

/* rtl/kpct_cfg.sv */
`timescale 1ns / 1ps

module kpct_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [kpct_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [kpct_pkg::REG_BITS-1:0]          cfg_data,
	output kpct_pkg::cfg_t                         cfg
);

	kpct_pkg::cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freeze_distance   <= kpct_pkg::FREEZE_DISTANCE_RST;
			cfg_q.change_tolerance  <= kpct_pkg::CHANGE_TOLERANCE_RST;
			cfg_q.external_unfreeze <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kpct_pkg::REG_FREEZE_DISTANCE:   cfg_q.freeze_distance   <= cfg_data;
				kpct_pkg::REG_CHANGE_TOLERANCE:  cfg_q.change_tolerance  <= cfg_data;
				kpct_pkg::REG_EXTERNAL_UNFREEZE: cfg_q.external_unfreeze <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/kpct_lane.sv */
`timescale 1ns / 1ps

module kpct_lane (
	input  kpct_pkg::sample_t   fresh,
	input  kpct_pkg::sample_t   stored,
	input  logic                frozen,
	input  kpct_pkg::cfg_t      cfg,
	output kpct_pkg::lane_res_t res
);

	kpct_pkg::sample_t gap;

	// Absolute distance between new sample and stored value
	assign gap = (fresh > stored) ? (fresh - stored) : (stored - fresh);

	// Unfreeze on movement unless only commands may unfreeze
	assign res.unfreeze = !cfg.external_unfreeze && frozen &&
		(gap > cfg.freeze_distance);
	assign res.moved    = res.unfreeze || (gap > cfg.change_tolerance);

endmodule

/* rtl/kpct_checker.sv */
`timescale 1ns / 1ps

module kpct_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_ready,
	input kpct_pkg::in_item_t                  item,
	input logic                                result_valid,
	input logic                                result_ready,
	input kpct_pkg::out_item_t                 result
);

	logic in_xfer;
	logic in_xfer_q;
	logic quiet_entry;

	assign in_xfer = item_valid && item_ready;

	// Remember whether the previous edge took a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_xfer_q <= 1'b0;
		end else begin
			in_xfer_q <= in_xfer;
		end
	end

	// Transfer into an empty block: no result ahead of this one
	assign quiet_entry = in_xfer && !result_valid && !in_xfer_q;

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// Every input transfer is followed by a valid result on the result side
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> ##1 result_valid)
		else $error("no result after input transfer");

	// Freeze all reports every knob frozen
	a_freeze_all: assert property (@(posedge clk) disable iff (!arst_n)
		quiet_entry && item.action == kpct_pkg::ACT_FREEZE_ALL
		|=> ##1 result_valid && result.frozen_mask == '1)
		else $error("freeze all left a knob unfrozen");

	// Unfreeze all reports no knob frozen
	a_unfreeze_all: assert property (@(posedge clk) disable iff (!arst_n)
		quiet_entry && item.action == kpct_pkg::ACT_UNFREEZE_ALL
		|=> ##1 result_valid && result.frozen_mask == '0)
		else $error("unfreeze all left a knob frozen");

endmodule

bind knob_pickup_change_tracker_top kpct_checker u_checker (.*);

/* dv/knob_pickup_change_tracker_top_tb.sv */
`timescale 1ns / 1ps

module knob_pickup_change_tracker_top_tb;
	import kpct_pkg::*;

	localparam logic [ACTION_BITS-1:0] ACT_FIRST_UNUSED = 3'd5;
	localparam sample_t    MAX_SAMPLE = '1;
	localparam knob_mask_t ALL_KNOBS  = '1;
	localparam knob_mask_t NO_KNOBS   = '0;

	typedef struct packed {
		bit                  is_cfg;
		logic [REG_BITS-1:0] fd;
		logic [REG_BITS-1:0] tol;
		logic                ext;
		bit                  typed;
		in_item_t            stim;
		out_item_t           want;
	} row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      item_valid = 1'b0;
	logic                      item_ready;
	in_item_t                  item = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	out_item_t                 result;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [REG_BITS-1:0]       cfg_data = '0;

	// Tracker state mirrored from the accepted transfers
	sample_t             knob_now [KNOB_COUNT];
	sample_t             knob_before [KNOB_COUNT];
	knob_mask_t          frozen_now = '0;
	knob_mask_t          moved_now = '0;
	logic [REG_BITS-1:0] cfg_freeze_dist = FREEZE_DISTANCE_RST;
	logic [REG_BITS-1:0] cfg_change_tol = CHANGE_TOLERANCE_RST;
	logic                cfg_ext_unfreeze = 1'b0;

	out_item_t knob_reports_due [$];
	int        mismatches = 0;
	bit        steady = 1'b0;
	row_t      plan [$];

	knob_pickup_change_tracker_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Apply one item to the mirrored state and return the report it produces
	function automatic out_item_t advance_tracker(in_item_t it);
		sample_t   fresh [KNOB_COUNT];
		int        gap;
		out_item_t rep;
		fresh[0] = it.sample_zero;
		fresh[1] = it.sample_one;
		fresh[2] = it.sample_two;
		fresh[3] = it.sample_three;
		case (it.action)
			ACT_SWEEP: begin
				moved_now = NO_KNOBS;
				for (int k = 0; k < KNOB_COUNT; k++) begin
					gap = int'(fresh[k]) - int'(knob_now[k]);
					if (gap < 0)
						gap = -gap;
					if (!cfg_ext_unfreeze && frozen_now[k] && gap > int'(cfg_freeze_dist)) begin
						frozen_now[k] = 1'b0;
						moved_now[k] = 1'b1;
					end
					if (gap > int'(cfg_change_tol))
						moved_now[k] = 1'b1;
					knob_before[k] = knob_now[k];
					knob_now[k] = fresh[k];
				end
			end
			ACT_FREEZE_ONE:   frozen_now[it.knob_index] = 1'b1;
			ACT_UNFREEZE_ONE: frozen_now[it.knob_index] = 1'b0;
			ACT_FREEZE_ALL:   frozen_now = ALL_KNOBS;
			ACT_UNFREEZE_ALL: frozen_now = NO_KNOBS;
			default: ;
		endcase
		rep.changed_mask   = moved_now;
		rep.frozen_mask    = frozen_now;
		rep.value_zero     = knob_now[0];
		rep.value_one      = knob_now[1];
		rep.value_two      = knob_now[2];
		rep.value_three    = knob_now[3];
		rep.previous_zero  = knob_before[0];
		rep.previous_one   = knob_before[1];
		rep.previous_two   = knob_before[2];
		rep.previous_three = knob_before[3];
		return rep;
	endfunction

	// Half the time land near a threshold so the boundaries get hit from both sides
	function automatic sample_t pick_sample(sample_t prior);
		int mode;
		int thr;
		int val;
		mode = $urandom_range(0, 9);
		thr = $urandom_range(0, 1) ? int'(cfg_freeze_dist) : int'(cfg_change_tol);
		if (mode < 5) begin
			val = int'(prior) + int'($urandom_range(0, 2 * (thr + 2))) - (thr + 2);
			if (val < 0)
				val = 0;
			if (val > int'(MAX_SAMPLE))
				val = int'(MAX_SAMPLE);
			return sample_t'(val);
		end
		case (mode)
			5, 6: return sample_t'($urandom_range(0, int'(MAX_SAMPLE)));
			7: return '0;
			8: return MAX_SAMPLE;
			default: return prior;
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			it.action = ACT_SWEEP;
		else if (roll < 65)
			it.action = ACT_FREEZE_ONE;
		else if (roll < 73)
			it.action = ACT_UNFREEZE_ONE;
		else if (roll < 79)
			it.action = ACT_FREEZE_ALL;
		else if (roll < 85)
			it.action = ACT_UNFREEZE_ALL;
		else
			it.action = ACT_FIRST_UNUSED + ACTION_BITS'($urandom_range(0, 2));
		it.knob_index   = INDEX_BITS'($urandom_range(0, KNOB_COUNT - 1));
		it.sample_zero  = pick_sample(knob_now[0]);
		it.sample_one   = pick_sample(knob_now[1]);
		it.sample_two   = pick_sample(knob_now[2]);
		it.sample_three = pick_sample(knob_now[3]);
		return it;
	endfunction

	function automatic row_t stim_row(logic [ACTION_BITS-1:0] act, logic [INDEX_BITS-1:0] idx,
			sample_t s0, sample_t s1, sample_t s2, sample_t s3);
		row_t r;
		r = '0;
		r.stim = '{act, idx, s0, s1, s2, s3};
		return r;
	endfunction

	// Same sample on every knob, same stored and previous value on every knob
	function automatic row_t typed_row(logic [ACTION_BITS-1:0] act, logic [INDEX_BITS-1:0] idx,
			sample_t s, knob_mask_t chg, knob_mask_t frz, sample_t v, sample_t p);
		row_t r;
		r = stim_row(act, idx, s, s, s, s);
		r.typed = 1'b1;
		r.want = '{chg, frz, v, v, v, v, p, p, p, p};
		return r;
	endfunction

	function automatic row_t config_row(logic [REG_BITS-1:0] fd, logic [REG_BITS-1:0] tol,
			logic ext);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.fd = fd;
		r.tol = tol;
		r.ext = ext;
		return r;
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch: %s", $realtime, msg);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got)
			note_mismatch($sformatf("%s expected %0d actual %0d", name, want, got));
	endfunction

	// Offer one item, hold it until the transfer, then record its report
	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		out_item_t rep;
		while (!steady && $urandom_range(0, 99) < 16) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		rep = advance_tracker(it);
		knob_reports_due.push_back(typed ? want : rep);
	endtask

	// Drain, then write all three registers
	task automatic apply_config(logic [REG_BITS-1:0] fd, logic [REG_BITS-1:0] tol, logic ext);
		item_valid <= 1'b0;
		while (knob_reports_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_FREEZE_DISTANCE;
		cfg_data <= fd;
		@(posedge clk);
		cfg_index <= REG_CHANGE_TOLERANCE;
		cfg_data <= tol;
		@(posedge clk);
		cfg_index <= REG_EXTERNAL_UNFREEZE;
		cfg_data <= REG_BITS'(ext);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_freeze_dist = fd;
		cfg_change_tol = tol;
		cfg_ext_unfreeze = ext;
	endtask

	// Stall the result side at random
	always @(posedge clk)
		result_ready <= steady || ($urandom_range(0, 99) >= 16);

	// Compare each result transfer with the oldest report due
	always @(posedge clk) begin : report_check
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (knob_reports_due.size() == 0) begin
				note_mismatch("result with no report due");
			end else begin
				want = knob_reports_due.pop_front();
				check_field("changed_mask", want.changed_mask, result.changed_mask);
				check_field("frozen_mask", want.frozen_mask, result.frozen_mask);
				check_field("value_zero", want.value_zero, result.value_zero);
				check_field("value_one", want.value_one, result.value_one);
				check_field("value_two", want.value_two, result.value_two);
				check_field("value_three", want.value_three, result.value_three);
				check_field("previous_zero", want.previous_zero, result.previous_zero);
				check_field("previous_one", want.previous_one, result.previous_one);
				check_field("previous_two", want.previous_two, result.previous_two);
				check_field("previous_three", want.previous_three, result.previous_three);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("knob_pickup_change_tracker_top regression: fail");
		$finish;
	end

	initial begin : stimulus
		logic [REG_BITS-1:0] phase_fd [8];
		logic [REG_BITS-1:0] phase_tol [8];
		logic                phase_ext [8];
		phase_fd = '{10'd8, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd3, 10'd16, 10'd0};
		phase_tol = '{10'd2, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd5, 10'd1, 10'd0};
		phase_ext = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
		for (int k = 0; k < KNOB_COUNT; k++) begin
			knob_now[k] = '0;
			knob_before[k] = '0;
		end

		// Directed rows: reset state, extremes, every action, unused codes,
		// a frozen knob just at and just past the distances, external unfreeze
		plan.push_back(typed_row(ACT_UNFREEZE_ALL, 2'd3, MAX_SAMPLE, NO_KNOBS, NO_KNOBS, '0, '0));
		plan.push_back(typed_row(ACT_SWEEP, 2'd0, MAX_SAMPLE, ALL_KNOBS, NO_KNOBS, MAX_SAMPLE, '0));
		plan.push_back(typed_row(ACT_FREEZE_ALL, 2'd0, '0, ALL_KNOBS, ALL_KNOBS, MAX_SAMPLE, '0));
		plan.push_back(typed_row(ACT_SWEEP, 2'd0, MAX_SAMPLE, NO_KNOBS, ALL_KNOBS, MAX_SAMPLE,
			MAX_SAMPLE));
		plan.push_back(stim_row(ACT_SWEEP, 2'd0, 10'd1014, 10'd1015, 10'd1021, 10'd1020));
		plan.push_back(stim_row(ACT_UNFREEZE_ONE, 2'd1, '0, '0, '0, '0));
		plan.push_back(stim_row(ACT_FREEZE_ONE, 2'd0, MAX_SAMPLE, '0, MAX_SAMPLE, '0));
		plan.push_back(stim_row(ACT_FREEZE_ONE, 2'd3, '0, MAX_SAMPLE, '0, MAX_SAMPLE));
		plan.push_back(stim_row(ACT_FIRST_UNUSED, 2'd2, MAX_SAMPLE, MAX_SAMPLE, '0, '0));
		plan.push_back(stim_row(ACT_FIRST_UNUSED + 3'd1, 2'd1, '0, '0, MAX_SAMPLE, MAX_SAMPLE));
		plan.push_back(stim_row(ACT_FIRST_UNUSED + 3'd2, 2'd3, 10'h155, 10'h2aa, 10'h155, 10'h2aa));
		plan.push_back(stim_row(ACT_SWEEP, 2'd0, '0, '0, '0, '0));
		plan.push_back(stim_row(ACT_UNFREEZE_ONE, 2'd2, '0, '0, '0, '0));
		plan.push_back(stim_row(ACT_FREEZE_ONE, 2'd2, '0, '0, '0, '0));
		plan.push_back(stim_row(ACT_UNFREEZE_ONE, 2'd3, '0, '0, '0, '0));
		plan.push_back(stim_row(ACT_UNFREEZE_ALL, 2'd1, MAX_SAMPLE, '0, MAX_SAMPLE, '0));
		plan.push_back(config_row(FREEZE_DISTANCE_RST, CHANGE_TOLERANCE_RST, 1'b1));
		plan.push_back(stim_row(ACT_FREEZE_ALL, 2'd0, '0, '0, '0, '0));
		plan.push_back(typed_row(ACT_SWEEP, 2'd0, MAX_SAMPLE, ALL_KNOBS, ALL_KNOBS, MAX_SAMPLE, '0));
		plan.push_back(config_row(FREEZE_DISTANCE_RST, CHANGE_TOLERANCE_RST, 1'b0));

		// Hold reset, then release
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				apply_config(plan[i].fd, plan[i].tol, plan[i].ext);
			else
				send_item(plan[i].stim, plan[i].typed, plan[i].want);
		end

		// Random phases, one register setting each; phase 3 runs with no idling
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 7) begin
				phase_fd[phase] = REG_BITS'($urandom_range(0, 1023));
				phase_tol[phase] = REG_BITS'($urandom_range(0, 31));
				phase_ext[phase] = 1'($urandom_range(0, 1));
			end
			apply_config(phase_fd[phase], phase_tol[phase], phase_ext[phase]);
			steady = (phase == 3);
			for (int n = 0; n < 100; n++)
				send_item(random_item(), 1'b0, '0);
		end
		steady = 1'b0;

		// Drain and let the pipeline settle
		item_valid <= 1'b0;
		while (knob_reports_due.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (mismatches == 0 && knob_reports_due.size() == 0)
			$display("knob_pickup_change_tracker_top regression: pass");
		else
			$display("knob_pickup_change_tracker_top regression: fail");
		$finish;
	end

endmodule
